@@ hdl/scbp_pkg.sv @@
// Package for the size class block pool: field widths, status codes,
// register indexes and the size-to-class function. No dependencies.
package scbp_pkg;

  localparam int unsigned SizeW      = 32;
  localparam int unsigned SlotW      = 6;
  localparam int unsigned ClassW     = 5;
  localparam int unsigned StatusW    = 3;
  localparam int unsigned BytesW     = 21;
  localparam int unsigned MaxBlocksW = 7;
  localparam int unsigned CfgIdxW    = 1;

  localparam int unsigned MaxClassesDef    = 17;
  localparam int unsigned SlotsPerClassDef = 64;

  localparam logic [BytesW-1:0]     MaxBlockSizeRst = 21'd4096;
  localparam logic [MaxBlocksW-1:0] MaxBlocksRst    = 7'd64;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgMaxBlockSize = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgMaxBlocks    = 1'b1;

  typedef enum logic [StatusW-1:0] {
    StFresh     = 3'd0,
    StReused    = 3'd1,
    StExhausted = 3'd2,
    StTooBig    = 3'd3,
    StRecycled  = 3'd4,
    StIgnored   = 3'd5,
    StQueueFull = 3'd6
  } status_e;

  // Class is the bit length of ((size - 1) mod 2^32) >> 4.
  function automatic logic [ClassW-1:0] size_class(input logic [SizeW-1:0] size);
    logic [SizeW-1:0]   dec;
    logic [SizeW-5:0]   v;
    logic [ClassW-1:0]  cls;
    dec = size - 32'd1;
    v   = dec[SizeW-1:4];
    cls = '0;
    for (int i = 0; i < SizeW - 4; i++) begin
      if (v[i]) cls = ClassW'(i + 1);
    end
    return cls;
  endfunction

endpackage

@@ hdl/size_class_block_pool.sv @@
// Top level of the size class block pool: class decode, per-class free
// queues and fresh-slot counters. Depends on scbp_pkg.
//
// Usage:
//   Request channel: drive kind_i, request_size_i and block_slot_i with
//   start_i high; a transaction is taken at any rising edge where start_i
//   is high and busy_o is low. busy_o never rises, so a new transaction can
//   enter on every clock.
//   Result channel: done_o pulses for one cycle with status_o, class_index_o,
//   granted_slot_o and block_bytes_o. Results come back through the stage 1
//   and stage 2 registers, in request order, one per request. The receiver
//   cannot stall; a result that is not taken in its cycle is gone.
//   Throughput: one transaction per cycle. The per-class counters and queue
//   pointers live in flip-flops and are updated in the decision cycle; the
//   slot queue memory is written or read at most once per transaction, with its
//   read data registered into the result stage.
//   Configuration: cfg_we_i with cfg_idx_i and cfg_data_i writes a register
//   at the clock edge; write only while no transaction is in flight.
//   Reset: counters, queue pointers and fill counts clear, registers return
//   to their defaults. Queue memory contents are not cleared; an entry is
//   only read after it was pushed.
module size_class_block_pool
  import scbp_pkg::*;
#(
  parameter int unsigned MAX_CLASSES     = MaxClassesDef,
  parameter int unsigned SLOTS_PER_CLASS = SlotsPerClassDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_idx_i,
  input  logic [BytesW-1:0]     cfg_data_i,
  // request
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic                  kind_i,
  input  logic [SizeW-1:0]      request_size_i,
  input  logic [SlotW-1:0]      block_slot_i,
  // result
  output logic                  done_o,
  output logic [StatusW-1:0]    status_o,
  output logic [ClassW-1:0]     class_index_o,
  output logic [SlotW-1:0]      granted_slot_o,
  output logic [BytesW-1:0]     block_bytes_o
);

  localparam int unsigned CntW   = $clog2(SLOTS_PER_CLASS + 1);
  localparam int unsigned PtrW   = (SLOTS_PER_CLASS > 1) ? $clog2(SLOTS_PER_CLASS) : 1;
  localparam int unsigned ClsIdxW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int unsigned Depth  = MAX_CLASSES * SLOTS_PER_CLASS;
  localparam int unsigned AddrW  = (Depth > 1) ? $clog2(Depth) : 1;

  localparam logic [CntW-1:0] SlotsCnt = CntW'(SLOTS_PER_CLASS);
  localparam logic [CntW-1:0] LimitRst =
    (32'(MaxBlocksRst) > 32'(SLOTS_PER_CLASS)) ? SlotsCnt : CntW'(MaxBlocksRst);

  // clamp the class count of a maximum block size to the classes we store
  function automatic logic [ClassW:0] class_count(input logic [BytesW-1:0] max_size);
    logic [ClassW:0] n;
    n = {1'b0, size_class(SizeW'(max_size))} + 6'd1;
    if (32'(n) > 32'(MAX_CLASSES)) n = (ClassW + 1)'(MAX_CLASSES);
    return n;
  endfunction

  // ---------------------------------------------------------------------
  // Configuration: keep the derived class count and fresh-slot limit.
  // ---------------------------------------------------------------------
  logic [ClassW:0] cls_count_q;
  logic [CntW-1:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cls_count_q <= class_count(MaxBlockSizeRst);
      limit_q     <= LimitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMaxBlockSize: cls_count_q <= class_count(cfg_data_i);
        CfgMaxBlocks: begin
          if (32'(cfg_data_i[MaxBlocksW-1:0]) > 32'(SLOTS_PER_CLASS)) begin
            limit_q <= SlotsCnt;
          end else begin
            limit_q <= CntW'(cfg_data_i[MaxBlocksW-1:0]);
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: decode the class and hold the request.
  // ---------------------------------------------------------------------
  logic              accept;
  logic              s1_vld_q;
  logic              s1_kind_q;
  logic [ClassW-1:0] s1_cls_q;
  logic [SlotW-1:0]  s1_slot_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_kind_q <= kind_i;
      s1_cls_q  <= size_class(request_size_i);
      s1_slot_q <= block_slot_i;
    end
  end

  // ---------------------------------------------------------------------
  // Per-class bookkeeping in flip-flops.
  // ---------------------------------------------------------------------
  logic [CntW-1:0] issued_q [MAX_CLASSES];
  logic [CntW-1:0] occ_q    [MAX_CLASSES];
  logic [PtrW-1:0] head_q   [MAX_CLASSES];
  logic [PtrW-1:0] tail_q   [MAX_CLASSES];

  logic               served;
  logic [ClsIdxW-1:0] cls_idx;
  logic [CntW-1:0]    issued_cur;
  logic [CntW-1:0]    occ_cur;
  logic [PtrW-1:0]    head_cur;
  logic [PtrW-1:0]    tail_cur;
  logic [PtrW-1:0]    head_nxt;
  logic [PtrW-1:0]    tail_nxt;
  logic               do_fresh;
  logic               do_reuse;
  logic               do_push;
  status_e            status_d;
  logic [AddrW-1:0]   mem_addr;

  assign served     = {1'b0, s1_cls_q} < cls_count_q;
  assign cls_idx    = ClsIdxW'(s1_cls_q);
  assign issued_cur = issued_q[cls_idx];
  assign occ_cur    = occ_q[cls_idx];
  assign head_cur   = head_q[cls_idx];
  assign tail_cur   = tail_q[cls_idx];

  // wrap pointers at the queue depth, which need not be a power of two
  assign head_nxt = (32'(head_cur) + 32'd1 == 32'(SLOTS_PER_CLASS)) ? '0 : head_cur + 1'b1;
  assign tail_nxt = (32'(tail_cur) + 32'd1 == 32'(SLOTS_PER_CLASS)) ? '0 : tail_cur + 1'b1;

  always_comb begin
    do_fresh = 1'b0;
    do_reuse = 1'b0;
    do_push  = 1'b0;
    status_d = StTooBig;
    if (!served) begin
      status_d = s1_kind_q ? StIgnored : StTooBig;
    end else if (!s1_kind_q) begin
      if (occ_cur != '0) begin
        do_reuse = s1_vld_q;
        status_d = StReused;
      end else if (issued_cur < limit_q) begin
        do_fresh = s1_vld_q;
        status_d = StFresh;
      end else begin
        status_d = StExhausted;
      end
    end else if (occ_cur >= SlotsCnt) begin
      status_d = StQueueFull;
    end else begin
      do_push  = s1_vld_q;
      status_d = StRecycled;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_CLASSES; i++) begin
        issued_q[i] <= '0;
        occ_q[i]    <= '0;
        head_q[i]   <= '0;
        tail_q[i]   <= '0;
      end
    end else begin
      if (do_fresh) issued_q[cls_idx] <= issued_cur + 1'b1;
      if (do_reuse) begin
        head_q[cls_idx] <= head_nxt;
        occ_q[cls_idx]  <= occ_cur - 1'b1;
      end
      if (do_push) begin
        tail_q[cls_idx] <= tail_nxt;
        occ_q[cls_idx]  <= occ_cur + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Free-slot queue memory: at most one access per transaction, registered read.
  // ---------------------------------------------------------------------
  logic [SlotW-1:0] free_slots_q [Depth];
  logic [SlotW-1:0] mem_rdata_q;

  assign mem_addr = AddrW'(cls_idx) * AddrW'(SLOTS_PER_CLASS)
                  + AddrW'(do_push ? tail_cur : head_cur);

  always_ff @(posedge clk_i) begin
    if (do_push)  free_slots_q[mem_addr] <= s1_slot_q;
    if (do_reuse) mem_rdata_q <= free_slots_q[mem_addr];
  end

  // ---------------------------------------------------------------------
  // Stage 2: result register.
  // ---------------------------------------------------------------------
  logic              s2_vld_q;
  status_e           s2_status_q;
  logic [ClassW-1:0] s2_cls_q;
  logic [SlotW-1:0]  s2_fresh_q;
  logic [BytesW-1:0] s2_bytes_q;
  logic [SizeW-1:0]  bytes_full;

  assign bytes_full = 32'd16 << s1_cls_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      s2_status_q <= status_d;
      s2_cls_q    <= s1_cls_q;
      s2_fresh_q  <= do_fresh ? SlotW'(issued_cur) : '0;
      s2_bytes_q  <= served ? bytes_full[BytesW-1:0] : '0;
    end
  end

  assign done_o         = s2_vld_q;
  assign status_o       = s2_status_q;
  assign class_index_o  = s2_cls_q;
  assign granted_slot_o = (s2_status_q == StReused) ? mem_rdata_q : s2_fresh_q;
  assign block_bytes_o  = s2_bytes_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_done_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 done_o)
    else $error("result missing two cycles after accepted transaction");

  a_occ_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && served) |-> (occ_cur <= SlotsCnt))
    else $error("free queue fill count beyond queue depth");

  a_refused_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (s2_status_q == StTooBig || s2_status_q == StIgnored))
      |-> (block_bytes_o == '0 && granted_slot_o == '0))
    else $error("refused transaction carries a grant or a size");

  a_one_queue_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({do_fresh, do_reuse, do_push}) <= 1)
    else $error("more than one bookkeeping action for a transaction");

endmodule
